### hw/rtl/ccip_pkg.sv
`default_nettype none
package ccip_pkg;

   localparam int MAX_POINTS_DEF = 64;

   localparam int KEY_W  = 32;
   localparam int STEP_W = 16;
   localparam int PT_W   = 16;
   localparam int PIDX_W = 6;
   localparam int CNT_W0 = 7;
   localparam int CSR_W  = 32;
   localparam int CSR_IDX_W = 3;
   localparam int SUM_W  = 34;

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_VALID = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_KEY   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_STEP    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_VALUE  = 3'd4;

   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   localparam logic signed [SUM_W-1:0] SUM_HI = 34'sd2147483647;
   localparam logic signed [SUM_W-1:0] SUM_LO = -34'sd2147483648;

   typedef enum logic [1:0] {
      SEL_INTERP = 2'd0,
      SEL_FIRST  = 2'd1,
      SEL_LAST   = 2'd2
   } sel_type;

   // side data carried through the segment divider
   typedef struct packed {
      logic                    req_type;
      logic [PIDX_W-1:0]       idx;
      logic signed [PT_W-1:0]  val;
      sel_type                 sel;
   } seg_tag_type;

   // side data carried through the slope divider
   typedef struct packed {
      logic                    look;
      logic signed [PT_W-1:0]  y0;
      logic                    neg;
   } slope_tag_type;

endpackage
`default_nettype wire

### hw/rtl/ccip_div.sv
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage.
// Needs num_i < den_i * 2**Q_W; den_i must be non-zero.
module ccip_div #(
   parameter int DEN_W = 16,
   parameter int Q_W   = 6,
   parameter int TAG_W = 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   valid_i,
   input  wire logic [DEN_W+Q_W-1:0]   num_i,
   input  wire logic [DEN_W-1:0]       den_i,
   input  wire logic [TAG_W-1:0]       tag_i,
   output      logic                   valid_o,
   output      logic [Q_W-1:0]         quo_o,
   output      logic [DEN_W-1:0]       rem_o,
   output      logic [TAG_W-1:0]       tag_o
);

   localparam int NUM_W = DEN_W + Q_W;

   logic             v_ff [Q_W];
   logic [NUM_W-1:0] r_ff [Q_W];
   logic [Q_W-1:0]   q_ff [Q_W];
   logic [DEN_W-1:0] d_ff [Q_W];
   logic [TAG_W-1:0] t_ff [Q_W];

   for (genvar g = 0; g < Q_W; g++) begin : g_stage
      localparam int B = Q_W - 1 - g;
      logic             v_prev;
      logic [NUM_W-1:0] r_prev;
      logic [Q_W-1:0]   q_prev;
      logic [DEN_W-1:0] d_prev;
      logic [TAG_W-1:0] t_prev;
      logic [NUM_W-1:0] trial;
      logic             ge;
      logic [NUM_W-1:0] r_in;
      logic [Q_W-1:0]   q_in;

      if (g == 0) begin : g_head
         assign v_prev = valid_i;
         assign r_prev = num_i;
         assign q_prev = '0;
         assign d_prev = den_i;
         assign t_prev = tag_i;
      end else begin : g_body
         assign v_prev = v_ff[g-1];
         assign r_prev = r_ff[g-1];
         assign q_prev = q_ff[g-1];
         assign d_prev = d_ff[g-1];
         assign t_prev = t_ff[g-1];
      end

      always_comb begin
         trial = NUM_W'(d_prev) << B;
         ge    = (r_prev >= trial);
         r_in  = ge ? (r_prev - trial) : r_prev;
         q_in  = q_prev;
         q_in[B] = ge;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else begin
            v_ff[g] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         r_ff[g] <= r_in;
         q_ff[g] <= q_in;
         d_ff[g] <= d_prev;
         t_ff[g] <= t_prev;
      end
   end

   assign valid_o = v_ff[Q_W-1];
   assign quo_o   = q_ff[Q_W-1];
   assign rem_o   = r_ff[Q_W-1][DEN_W-1:0];
   assign tag_o   = t_ff[Q_W-1];

endmodule
`default_nettype wire

### hw/rtl/calibration_curve_interpolator_core.sv
// An accepted request beat passes S0 to S2, the segment divider, S3, S4, the
// slope divider, S5 and S6 before its rsp_valid strobe.
// Throughput: one request per cycle, busy is never raised; the depth comes
// from the two bit-per-stage dividers (segment index, then slope fraction).
// Reset clears the pipeline valid bits and the configuration registers; point memory is
// not cleared. The receiver cannot stall: every result shows for one cycle.
`default_nettype none
module calibration_curve_interpolator_core #(
   parameter int MAX_POINTS = ccip_pkg::MAX_POINTS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output      logic                                busy,
   input  wire logic                                req_type,
   input  wire logic [ccip_pkg::PIDX_W-1:0]         req_point_index,
   input  wire logic signed [ccip_pkg::PT_W-1:0]    req_point_value,
   input  wire logic signed [ccip_pkg::KEY_W-1:0]   req_lookup_key,
   output      logic                                rsp_valid,
   output      logic signed [ccip_pkg::KEY_W-1:0]   rsp_result_value,
   output      logic                                rsp_saturated,
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [ccip_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [ccip_pkg::CSR_W-1:0]          csr_data
);

   localparam int IDX_W  = $clog2(MAX_POINTS);
   localparam int CNT_W  = ($clog2(MAX_POINTS + 1) > ccip_pkg::CNT_W0) ?
                           $clog2(MAX_POINTS + 1) : ccip_pkg::CNT_W0;
   localparam int SPAN_W = ccip_pkg::STEP_W + IDX_W;
   localparam int SW     = ccip_pkg::SUM_W;
   localparam int PW     = ccip_pkg::PT_W;
   localparam int LAT    = 23 + IDX_W;

   // ---------------- configuration registers
   logic                                table_valid_ff, table_valid_in;
   logic signed [ccip_pkg::KEY_W-1:0]   start_key_ff, start_key_in;
   logic signed [ccip_pkg::STEP_W-1:0]  key_step_ff, key_step_in;
   logic [ccip_pkg::CNT_W0-1:0]         point_count_ff, point_count_in;
   logic signed [ccip_pkg::KEY_W-1:0]   base_value_ff, base_value_in;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_comb begin
      table_valid_in = table_valid_ff;
      start_key_in   = start_key_ff;
      key_step_in    = key_step_ff;
      point_count_in = point_count_ff;
      base_value_in  = base_value_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            ccip_pkg::CSR_TABLE_VALID: table_valid_in = csr_data[0];
            ccip_pkg::CSR_START_KEY:   start_key_in   = $signed(csr_data);
            ccip_pkg::CSR_KEY_STEP:    key_step_in    = $signed(csr_data[15:0]);
            ccip_pkg::CSR_POINT_COUNT: point_count_in = csr_data[6:0];
            ccip_pkg::CSR_BASE_VALUE:  base_value_in  = $signed(csr_data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_valid_ff <= 1'b0;
         start_key_ff   <= '0;
         key_step_ff    <= '0;
         point_count_ff <= 7'd1;
         base_value_ff  <= '0;
      end else begin
         table_valid_ff <= table_valid_in;
         start_key_ff   <= start_key_in;
         key_step_ff    <= key_step_in;
         point_count_ff <= point_count_in;
         base_value_ff  <= base_value_in;
      end
   end

   // values derived from the registers
   logic                       step_up;
   logic [ccip_pkg::STEP_W-1:0] astep_c, den_c;
   logic [CNT_W-1:0]            cnt_ext, cnt_c;
   logic [IDX_W-1:0]            cnt_m1_c;
   logic [SPAN_W-1:0]           span_ff, span_in;
   logic [IDX_W-1:0]            cnt_m1_ff;

   always_comb begin
      step_up = !key_step_ff[ccip_pkg::STEP_W-1];
      astep_c = step_up ? key_step_ff : -key_step_ff;
      den_c   = (astep_c == '0) ? ccip_pkg::STEP_W'(1) : astep_c;
      cnt_ext = CNT_W'(point_count_ff);
      if (cnt_ext == '0) begin
         cnt_c = CNT_W'(1);
      end else if (cnt_ext > CNT_W'(MAX_POINTS)) begin
         cnt_c = CNT_W'(MAX_POINTS);
      end else begin
         cnt_c = cnt_ext;
      end
      cnt_m1_c = IDX_W'(cnt_c - CNT_W'(1));
      span_in  = SPAN_W'(astep_c) * SPAN_W'(cnt_m1_c);
   end

   always_ff @(posedge clock) begin
      span_ff   <= span_in;
      cnt_m1_ff <= cnt_m1_c;
   end

   // ---------------- S0: request register
   logic                               s0_v_ff;
   logic                               s0_type_ff;
   logic [ccip_pkg::PIDX_W-1:0]        s0_idx_ff;
   logic signed [PW-1:0]               s0_val_ff;
   logic signed [ccip_pkg::KEY_W-1:0]  s0_key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else begin
         s0_v_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      s0_type_ff <= req_type;
      s0_idx_ff  <= req_point_index;
      s0_val_ff  <= req_point_value;
      s0_key_ff  <= req_lookup_key;
   end

   // ---------------- S1: distance from the first grid key
   logic                        s1_v_ff;
   logic                        s1_type_ff;
   logic [ccip_pkg::PIDX_W-1:0] s1_idx_ff;
   logic signed [PW-1:0]        s1_val_ff;
   logic signed [SW-1:0]        s1_dist_ff, s1_dist_in;

   always_comb begin
      if (!key_step_ff[ccip_pkg::STEP_W-1]) begin
         s1_dist_in = SW'(s0_key_ff) - SW'(start_key_ff);
      end else begin
         s1_dist_in = SW'(start_key_ff) - SW'(s0_key_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s0_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_type_ff <= s0_type_ff;
      s1_idx_ff  <= s0_idx_ff;
      s1_val_ff  <= s0_val_ff;
      s1_dist_ff <= s1_dist_in;
   end

   // ---------------- S2: end checks
   logic                  s2_v_ff;
   ccip_pkg::seg_tag_type s2_tag_ff, s2_tag_in;
   logic [SPAN_W-1:0]     s2_num_ff, s2_num_in;

   always_comb begin
      s2_tag_in.req_type = s1_type_ff;
      s2_tag_in.idx      = s1_idx_ff;
      s2_tag_in.val      = s1_val_ff;
      s2_num_in          = '0;
      if (s1_dist_ff <= 0) begin
         s2_tag_in.sel = ccip_pkg::SEL_FIRST;
      end else if (s1_dist_ff >= $signed(SW'(span_ff))) begin
         s2_tag_in.sel = ccip_pkg::SEL_LAST;
      end else begin
         s2_tag_in.sel = ccip_pkg::SEL_INTERP;
         s2_num_in     = s1_dist_ff[SPAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_tag_ff <= s2_tag_in;
      s2_num_ff <= s2_num_in;
   end

   // ---------------- segment index and offset
   logic                           d1_v;
   logic [IDX_W-1:0]               d1_seg;
   logic [ccip_pkg::STEP_W-1:0]    d1_off;
   logic [$bits(ccip_pkg::seg_tag_type)-1:0] d1_tag_vec;
   ccip_pkg::seg_tag_type          d1_tag;

   ccip_div #(
      .DEN_W (ccip_pkg::STEP_W),
      .Q_W   (IDX_W),
      .TAG_W ($bits(ccip_pkg::seg_tag_type))
   ) u_seg_div (
      .clock   (clock),
      .reset   (reset),
      .valid_i (s2_v_ff),
      .num_i   (s2_num_ff),
      .den_i   (den_c),
      .tag_i   (s2_tag_ff),
      .valid_o (d1_v),
      .quo_o   (d1_seg),
      .rem_o   (d1_off),
      .tag_o   (d1_tag_vec)
   );

   assign d1_tag = ccip_pkg::seg_tag_type'(d1_tag_vec);

   // ---------------- S3: point memory
   logic signed [PW-1:0] point_mem [MAX_POINTS];
   logic [IDX_W-1:0]     addr_a, addr_b, wr_addr;
   logic [31:0]          wr_idx_ext;
   logic                 wr_en;
   logic signed [PW-1:0] rd_a_ff, rd_b_ff;
   logic                 s3_v_ff;
   logic                 s3_look_ff;
   logic [ccip_pkg::STEP_W-1:0] s3_off_ff, s3_off_in;

   always_comb begin
      case (d1_tag.sel)
         ccip_pkg::SEL_FIRST: addr_a = '0;
         ccip_pkg::SEL_LAST:  addr_a = cnt_m1_ff;
         default:             addr_a = d1_seg;
      endcase
      addr_b     = d1_seg + IDX_W'(1);
      s3_off_in  = (d1_tag.sel == ccip_pkg::SEL_INTERP) ? d1_off : '0;
      wr_idx_ext = 32'(d1_tag.idx);
      wr_addr    = wr_idx_ext[IDX_W-1:0];
      wr_en      = d1_v && (d1_tag.req_type == ccip_pkg::REQ_WRITE) &&
                   (wr_idx_ext < 32'(MAX_POINTS));
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         point_mem[wr_addr] <= d1_tag.val;
      end
      rd_a_ff <= point_mem[addr_a];
      rd_b_ff <= point_mem[addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else begin
         s3_v_ff <= d1_v;
      end
   end

   always_ff @(posedge clock) begin
      s3_look_ff <= (d1_tag.req_type == ccip_pkg::REQ_LOOKUP);
      s3_off_ff  <= s3_off_in;
   end

   // ---------------- S4: point difference times offset
   logic                    s4_v_ff;
   ccip_pkg::slope_tag_type s4_tag_ff, s4_tag_in;
   logic [31:0]             s4_prod_ff, s4_prod_in;
   logic signed [PW:0]      dy;
   logic [PW-1:0]           dy_mag;

   always_comb begin
      dy     = (PW+1)'(rd_b_ff) - (PW+1)'(rd_a_ff);
      dy_mag = dy[PW] ? PW'(-dy) : dy[PW-1:0];
      s4_prod_in      = 32'(dy_mag) * 32'(s3_off_ff);
      s4_tag_in.look  = s3_look_ff;
      s4_tag_in.y0    = rd_a_ff;
      s4_tag_in.neg   = dy[PW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else begin
         s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_tag_ff  <= s4_tag_in;
      s4_prod_ff <= s4_prod_in;
   end

   // ---------------- slope fraction, truncated towards zero on magnitudes
   logic                          d2_v;
   logic [PW-1:0]                 d2_quo;
   logic [ccip_pkg::STEP_W-1:0]   d2_rem;
   logic [$bits(ccip_pkg::slope_tag_type)-1:0] d2_tag_vec;
   ccip_pkg::slope_tag_type       d2_tag;

   ccip_div #(
      .DEN_W (ccip_pkg::STEP_W),
      .Q_W   (PW),
      .TAG_W ($bits(ccip_pkg::slope_tag_type))
   ) u_slope_div (
      .clock   (clock),
      .reset   (reset),
      .valid_i (s4_v_ff),
      .num_i   (s4_prod_ff),
      .den_i   (den_c),
      .tag_i   (s4_tag_ff),
      .valid_o (d2_v),
      .quo_o   (d2_quo),
      .rem_o   (d2_rem),
      .tag_o   (d2_tag_vec)
   );

   assign d2_tag = ccip_pkg::slope_tag_type'(d2_tag_vec);

   // ---------------- S5: sum with base
   logic                 s5_v_ff;
   logic                 s5_look_ff;
   logic signed [SW-1:0] s5_sum_ff, s5_sum_in;
   logic signed [PW:0]   frac;

   always_comb begin
      frac = d2_tag.neg ? -$signed({1'b0, d2_quo}) : $signed({1'b0, d2_quo});
      s5_sum_in = SW'(d2_tag.y0) + SW'(frac) + SW'(base_value_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
      end else begin
         s5_v_ff <= d2_v;
      end
   end

   always_ff @(posedge clock) begin
      s5_look_ff <= d2_tag.look;
      s5_sum_ff  <= s5_sum_in;
   end

   // ---------------- S6: clamp and result beat
   logic                               rsp_valid_ff;
   logic signed [ccip_pkg::KEY_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                               rsp_sat_ff, rsp_sat_in;

   // flags stay low between beats
   always_comb begin
      rsp_value_in = '0;
      rsp_sat_in   = 1'b0;
      if (s5_v_ff && s5_look_ff && table_valid_ff) begin
         if (s5_sum_ff > ccip_pkg::SUM_HI) begin
            rsp_value_in = ccip_pkg::SUM_HI[31:0];
            rsp_sat_in   = 1'b1;
         end else if (s5_sum_ff < ccip_pkg::SUM_LO) begin
            rsp_value_in = ccip_pkg::SUM_LO[31:0];
            rsp_sat_in   = 1'b1;
         end else begin
            rsp_value_in = s5_sum_ff[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s5_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_saturated    = rsp_sat_ff;

   // ---------------- checks
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("request beat without result at fixed latency");

   a_sat_only_on_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_saturated |-> rsp_valid)
      else $error("saturated flag outside a result beat");

   a_sat_clamps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_result_value == ccip_pkg::SUM_HI[31:0] ||
          rsp_result_value == ccip_pkg::SUM_LO[31:0]))
      else $error("saturated result not at a range limit");

   a_invalid_table_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !table_valid_ff) |->
         (rsp_result_value == '0 && !rsp_saturated))
      else $error("non-zero result with an invalid table");

endmodule
`default_nettype wire
